@@ hw/rtl/mips_single_cycle_core_top_macros.svh @@
// Assertion macros for the MIPS core block.
`ifndef MIPS_SINGLE_CYCLE_CORE_TOP_MACROS_SVH
`define MIPS_SINGLE_CYCLE_CORE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MSCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MSCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mscc_pkg.sv @@
// Shared constants, codes and helpers for the MIPS core block.
package mscc_pkg;

  localparam int DATA_WORDS = 1024;
  localparam int DATA_AW = $clog2(DATA_WORDS);
  localparam logic [DATA_AW-1:0] DATA_LAST = DATA_AW'(DATA_WORDS - 1);

  localparam logic [31:0] SP_RESET = 32'h0100_0000;
  localparam logic [31:0] RA_RESET = 32'hFFFF_FFFF;
  localparam logic [31:0] HALT_ADDR = 32'hFFFF_FFFF;
  localparam logic [31:0] REGION_MASK = 32'hF000_0000;
  localparam logic [31:0] SEQ_STEP = 32'd4;
  localparam logic [31:0] LINK_STEP = 32'd8;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_SP = 5'd29;
  localparam logic [4:0] REG_RA = 5'd31;

  typedef enum logic [5:0] {
    OP_SPECIAL = 6'h00,
    OP_J       = 6'h02,
    OP_JAL     = 6'h03,
    OP_BEQ     = 6'h04,
    OP_BNE     = 6'h05,
    OP_ADDIU   = 6'h09,
    OP_SLTI    = 6'h0A,
    OP_LW      = 6'h23,
    OP_SW      = 6'h2B
  } opcode_t;

  typedef enum logic [5:0] {
    FN_SLL  = 6'h00,
    FN_SRL  = 6'h02,
    FN_JR   = 6'h08,
    FN_ADD  = 6'h20,
    FN_ADDU = 6'h21,
    FN_SUB  = 6'h22,
    FN_SUBU = 6'h23,
    FN_AND  = 6'h24,
    FN_OR   = 6'h25,
    FN_NOR  = 6'h27,
    FN_SLT  = 6'h2A,
    FN_SLTU = 6'h2B
  } funct_t;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_access_t;

  function automatic logic [31:0] reg_reset_value(input logic [4:0] idx);
    logic [31:0] v;
    v = '0;
    if (idx == REG_SP) begin
      v = SP_RESET;
    end else if (idx == REG_RA) begin
      v = RA_RESET;
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/mscc_if.sv @@
// Valid/ready channel interfaces for instruction words and result words.
interface mscc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source(output valid, output instruction_word, input ready);
  modport sink(input valid, input instruction_word, output ready);
endinterface

interface mscc_out_if;
  logic                  valid;
  logic                  ready;
  logic [31:0]           instruction_address;
  logic [31:0]           next_address;
  logic                  reg_write_enable;
  logic [4:0]            reg_write_index;
  logic [31:0]           reg_write_value;
  mscc_pkg::mem_access_t mem_access;
  logic [31:0]           mem_address;
  logic [31:0]           mem_data;
  logic                  access_misaligned;
  logic                  illegal_instruction;
  logic                  halted;

  modport source(
    output valid, output instruction_address, output next_address,
    output reg_write_enable, output reg_write_index, output reg_write_value,
    output mem_access, output mem_address, output mem_data,
    output access_misaligned, output illegal_instruction, output halted,
    input ready
  );
  modport sink(
    input valid, input instruction_address, input next_address,
    input reg_write_enable, input reg_write_index, input reg_write_value,
    input mem_access, input mem_address, input mem_data,
    input access_misaligned, input illegal_instruction, input halted,
    output ready
  );
endinterface

@@ hw/rtl/mips_single_cycle_core_top.sv @@
// MIPS32 integer-subset core: register file and data memory in synchronous RAMs.
//
// instr carries one instruction word, the one fetched at the current program
// counter; result carries one word per instruction: the register write, the
// memory access, the next fetch address and the flags.
// An instruction taken is registered into the execute stage and then into the
// write-back stage, where its result word is valid until accepted.
// Throughput: one instruction per cycle while result.ready is high, loads
// included. Register file reads are issued as the word is taken; the older
// instruction's write is forwarded from the write-back stage, and load data
// comes straight from the data memory's output register, so no bubble is needed.
// Reset (rst, synchronous): program counter 0, r29 = 0x01000000, r31 all ones,
// other registers zero. The data memory is then cleared one word per cycle,
// all DATA_WORDS (1024) words, during which instr.ready stays low.
// Stall: while result.ready is low the result word holds, one more
// instruction can be taken into the execute stage, then instr.ready drops.
// Once next_address reaches 0xFFFFFFFF the core is halted; later words change
// nothing and report halted with both addresses equal to the program counter.
`include "mips_single_cycle_core_top_macros.svh"

module mips_single_cycle_core_top (
  input  logic        clk,
  input  logic        rst,
  mscc_in_if.sink     instr,
  mscc_out_if.source  result
);

  logic                         clearing;
  logic [mscc_pkg::DATA_AW-1:0] clear_idx;

  logic x_valid;
  logic w_valid;
  logic w_first;
  logic w_adv;
  logic x_fire;
  logic in_fire;

  logic [31:0] pc;
  logic        stopped;

  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid;
  logic        rf_we;
  logic [4:0]  rs_in;
  logic [4:0]  rt_in;
  logic        rs_bypass;
  logic        rt_bypass;
  logic        rs_fix;
  logic        rt_fix;
  logic [31:0] rs_fixval;
  logic [31:0] rt_fixval;
  logic [31:0] rs_mem_q;
  logic [31:0] rt_mem_q;
  logic        rs_fix_q;
  logic        rt_fix_q;
  logic [31:0] rs_fixval_q;
  logic [31:0] rt_fixval_q;

  logic [31:0] x_word;
  logic [5:0]  x_op;
  logic [4:0]  x_rs;
  logic [4:0]  x_rt;
  logic [4:0]  x_rd;
  logic [4:0]  x_sh;
  logic [5:0]  x_fn;
  logic [31:0] x_imm;
  logic [31:0] x_seq;
  logic [31:0] x_jtarget;
  logic [31:0] x_btarget;
  logic [31:0] x_a;
  logic [31:0] x_b;

  logic                  x_wen;
  logic [4:0]            x_idx;
  logic [31:0]           x_val;
  logic [31:0]           x_next;
  mscc_pkg::mem_access_t x_macc;
  logic [31:0]           x_maddr;
  logic [31:0]           x_store;
  logic                  x_mis;
  logic                  x_ill;
  logic                  x_halt;
  logic                  x_load;
  logic                  x_mem_we;
  logic [mscc_pkg::DATA_AW-1:0] x_widx;

  logic [31:0] dm_mem [mscc_pkg::DATA_WORDS];
  logic [31:0] dm_rdata;

  logic [31:0]           w_pc;
  logic [31:0]           w_next;
  logic                  w_wen;
  logic [4:0]            w_idx;
  logic [31:0]           w_alu;
  logic                  w_load;
  mscc_pkg::mem_access_t w_macc;
  logic [31:0]           w_maddr;
  logic [31:0]           w_store;
  logic                  w_mis;
  logic                  w_ill;
  logic                  w_halt;
  logic [31:0]           w_value;

  // memory clearing after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_idx <= '0;
    end else if (clearing) begin
      clear_idx <= clear_idx + 1'b1;
      if (clear_idx == mscc_pkg::DATA_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // pipeline control
  assign w_adv       = !w_valid || result.ready;
  assign x_fire      = x_valid && w_adv;
  assign instr.ready = !clearing && (!x_valid || w_adv);
  assign in_fire     = instr.valid && instr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
      w_valid <= 1'b0;
      w_first <= 1'b0;
    end else begin
      if (in_fire) begin
        x_valid <= 1'b1;
      end else if (x_fire) begin
        x_valid <= 1'b0;
      end
      if (x_fire) begin
        w_valid <= 1'b1;
      end else if (result.ready) begin
        w_valid <= 1'b0;
      end
      w_first <= x_fire;
    end
  end

  // register file: read at accept, written in the first write-back cycle
  assign rf_we   = w_valid && w_first && w_wen;
  assign w_value = w_load ? dm_rdata : w_alu;
  assign rs_in   = instr.instruction_word[25:21];
  assign rt_in   = instr.instruction_word[20:16];

  always_comb begin
    rs_bypass = rf_we && (w_idx == rs_in);
    rt_bypass = rf_we && (w_idx == rt_in);
    rs_fix    = rs_bypass || (rs_in == mscc_pkg::REG_ZERO) || !rf_valid[rs_in];
    rt_fix    = rt_bypass || (rt_in == mscc_pkg::REG_ZERO) || !rf_valid[rt_in];
    if (rs_in == mscc_pkg::REG_ZERO) begin
      rs_fixval = '0;
    end else if (rs_bypass) begin
      rs_fixval = w_value;
    end else begin
      rs_fixval = mscc_pkg::reg_reset_value(rs_in);
    end
    if (rt_in == mscc_pkg::REG_ZERO) begin
      rt_fixval = '0;
    end else if (rt_bypass) begin
      rt_fixval = w_value;
    end else begin
      rt_fixval = mscc_pkg::reg_reset_value(rt_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[w_idx] <= w_value;
    end
    if (in_fire) begin
      rs_mem_q <= rf_mem[rs_in];
      rt_mem_q <= rf_mem[rt_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[w_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_word      <= instr.instruction_word;
      rs_fix_q    <= rs_fix;
      rt_fix_q    <= rt_fix;
      rs_fixval_q <= rs_fixval;
      rt_fixval_q <= rt_fixval;
    end
  end

  // execute stage
  assign x_op      = x_word[31:26];
  assign x_rs      = x_word[25:21];
  assign x_rt      = x_word[20:16];
  assign x_rd      = x_word[15:11];
  assign x_sh      = x_word[10:6];
  assign x_fn      = x_word[5:0];
  assign x_imm     = {{16{x_word[15]}}, x_word[15:0]};
  assign x_seq     = pc + mscc_pkg::SEQ_STEP;
  assign x_jtarget = (x_seq & mscc_pkg::REGION_MASK) | {4'b0000, x_word[25:0], 2'b00};
  assign x_btarget = x_seq + {x_imm[29:0], 2'b00};

  always_comb begin
    x_a = rs_fix_q ? rs_fixval_q : rs_mem_q;
    x_b = rt_fix_q ? rt_fixval_q : rt_mem_q;
    if (w_valid && w_wen && (w_idx == x_rs)) begin
      x_a = w_value;
    end
    if (w_valid && w_wen && (w_idx == x_rt)) begin
      x_b = w_value;
    end
  end

  always_comb begin
    x_wen    = 1'b0;
    x_idx    = '0;
    x_val    = '0;
    x_next   = x_seq;
    x_macc   = mscc_pkg::MEM_NONE;
    x_maddr  = '0;
    x_store  = '0;
    x_mis    = 1'b0;
    x_ill    = 1'b0;
    x_load   = 1'b0;
    x_mem_we = 1'b0;
    case (x_op)
      mscc_pkg::OP_SPECIAL: begin
        x_wen = 1'b1;
        x_idx = x_rd;
        case (x_fn)
          mscc_pkg::FN_SLL:  x_val = x_b << x_sh;
          mscc_pkg::FN_SRL:  x_val = x_b >> x_sh;
          mscc_pkg::FN_JR: begin
            x_wen  = 1'b0;
            x_next = x_a;
          end
          mscc_pkg::FN_ADD,
          mscc_pkg::FN_ADDU: x_val = x_a + x_b;
          mscc_pkg::FN_SUB,
          mscc_pkg::FN_SUBU: x_val = x_a - x_b;
          mscc_pkg::FN_AND:  x_val = x_a & x_b;
          mscc_pkg::FN_OR:   x_val = x_a | x_b;
          mscc_pkg::FN_NOR:  x_val = ~(x_a | x_b);
          mscc_pkg::FN_SLT:  x_val = {31'd0, $signed(x_a) < $signed(x_b)};
          mscc_pkg::FN_SLTU: x_val = {31'd0, x_a < x_b};
          default: begin
            x_wen = 1'b0;
            x_ill = 1'b1;
          end
        endcase
      end
      mscc_pkg::OP_J: x_next = x_jtarget;
      mscc_pkg::OP_JAL: begin
        x_wen  = 1'b1;
        x_idx  = mscc_pkg::REG_RA;
        x_val  = pc + mscc_pkg::LINK_STEP;
        x_next = x_jtarget;
      end
      mscc_pkg::OP_BEQ: begin
        if (x_a == x_b) begin
          x_next = x_btarget;
        end
      end
      mscc_pkg::OP_BNE: begin
        if (x_a != x_b) begin
          x_next = x_btarget;
        end
      end
      mscc_pkg::OP_ADDIU: begin
        x_wen = 1'b1;
        x_idx = x_rt;
        x_val = x_a + x_imm;
      end
      mscc_pkg::OP_SLTI: begin
        x_wen = 1'b1;
        x_idx = x_rt;
        x_val = {31'd0, $signed(x_a) < $signed(x_imm)};
      end
      mscc_pkg::OP_LW: begin
        x_macc  = mscc_pkg::MEM_LOAD;
        x_maddr = x_a + x_imm;
        if (x_maddr[1:0] != 2'b00) begin
          x_mis = 1'b1;
        end else begin
          x_load = 1'b1;
          x_wen  = 1'b1;
          x_idx  = x_rt;
        end
      end
      mscc_pkg::OP_SW: begin
        x_macc  = mscc_pkg::MEM_STORE;
        x_maddr = x_a + x_imm;
        if (x_maddr[1:0] != 2'b00) begin
          x_mis = 1'b1;
        end else begin
          x_store  = x_b;
          x_mem_we = 1'b1;
        end
      end
      default: x_ill = 1'b1;
    endcase
    if (x_wen && (x_idx == mscc_pkg::REG_ZERO)) begin
      x_wen = 1'b0;
    end
    if (!x_wen) begin
      x_idx = '0;
      x_val = '0;
    end
    x_halt = (x_next == mscc_pkg::HALT_ADDR);
    if (stopped) begin
      x_wen    = 1'b0;
      x_idx    = '0;
      x_val    = '0;
      x_next   = pc;
      x_macc   = mscc_pkg::MEM_NONE;
      x_maddr  = '0;
      x_store  = '0;
      x_mis    = 1'b0;
      x_ill    = 1'b0;
      x_load   = 1'b0;
      x_mem_we = 1'b0;
      x_halt   = 1'b1;
    end
  end

  assign x_widx = x_maddr[2 +: mscc_pkg::DATA_AW];

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= '0;
      stopped <= 1'b0;
    end else if (x_fire) begin
      pc      <= x_next;
      stopped <= x_halt;
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (clearing) begin
      dm_mem[clear_idx] <= '0;
    end else if (x_fire && x_mem_we) begin
      dm_mem[x_widx] <= x_b;
    end
    if (x_fire && x_load) begin
      dm_rdata <= dm_mem[x_widx];
    end
  end

  // write-back stage
  always_ff @(posedge clk) begin
    if (x_fire) begin
      w_pc    <= pc;
      w_next  <= x_next;
      w_wen   <= x_wen;
      w_idx   <= x_idx;
      w_alu   <= x_val;
      w_load  <= x_load;
      w_macc  <= x_macc;
      w_maddr <= x_maddr;
      w_store <= x_store;
      w_mis   <= x_mis;
      w_ill   <= x_ill;
      w_halt  <= x_halt;
    end
  end

  assign result.valid               = w_valid;
  assign result.instruction_address = w_pc;
  assign result.next_address        = w_next;
  assign result.reg_write_enable    = w_wen;
  assign result.reg_write_index     = w_idx;
  assign result.reg_write_value     = w_wen ? w_value : '0;
  assign result.mem_access          = w_macc;
  assign result.mem_address         = w_maddr;
  assign result.mem_data            = w_load ? dm_rdata : w_store;
  assign result.access_misaligned   = w_mis;
  assign result.illegal_instruction = w_ill;
  assign result.halted              = w_halt;

  `MSCC_ASSERT_NOW(a_no_work_while_clearing, clearing, !x_valid && !w_valid, "work during clear")
  `MSCC_ASSERT_NOW(a_no_r0_write, w_valid, !(w_wen && (w_idx == mscc_pkg::REG_ZERO)), "r0 written")
  `MSCC_ASSERT_NOW(a_halt_addr, w_valid && w_halt, w_next == mscc_pkg::HALT_ADDR, "halt addr")
  `MSCC_ASSERT_NEXT(a_stopped_quiet, x_fire && stopped, w_valid && w_halt && !w_wen && !w_load, "effect after halt")
  `MSCC_ASSERT_NEXT(a_result_holds, w_valid && !result.ready, w_valid && $stable(w_pc) && $stable(w_next), "result lost")

endmodule
